### rtl/core/bmfs_pkg.sv
// Package for the battery mode and FET sequencer.
// Holds the mode, system state and sequencer step codes, register indexes and beat types.
// Depends on nothing; every other file of the block but bmfs_stream_if imports it.
`default_nettype none

package bmfs_pkg;

  localparam int TIMER_W = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_DSG  = 2'd1,
    MODE_CHG  = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    ST_WORK           = 4'd0,
    ST_FAULT          = 4'd1,
    ST_UPDATING       = 4'd2,
    ST_CHARGE_IN      = 4'd3,
    ST_FULL           = 4'd4,
    ST_CHARGE_FAIL    = 4'd5,
    ST_CHARGING       = 4'd6,
    ST_DISCHARGING    = 4'd7,
    ST_SLEEP          = 4'd8,
    ST_DISCHARGE_FAIL = 4'd9
  } sys_state_t;

  typedef enum logic [1:0] {
    SEQ_PRE     = 2'd0,
    SEQ_OVERLAP = 2'd1,
    SEQ_MAIN    = 2'd2
  } seq_step_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DSG_THRESHOLD = 3'd0,
    CFG_CHG_THRESHOLD = 3'd1,
    CFG_MODE_TICKS    = 3'd2,
    CFG_PRE_TICKS     = 3'd3,
    CFG_OVERLAP_TICKS = 3'd4
  } cfg_index_t;

  localparam logic [15:0] DSG_THRESHOLD_RESET = 16'd300;
  localparam logic [15:0] CHG_THRESHOLD_RESET = 16'd200;
  localparam logic [15:0] MODE_TICKS_RESET    = 16'd30;
  localparam logic [15:0] PRE_TICKS_RESET     = 16'd50;
  localparam logic [9:0]  OVERLAP_TICKS_RESET = 10'd10;

  typedef struct packed {
    logic        data_valid;
    logic [15:0] discharge_current;
    logic [15:0] charge_current;
    logic [6:0]  charge_flags;
    logic [4:0]  discharge_flags;
    logic        hard_fault;
    logic        upgrading;
    logic [2:0]  allow_flags;
    logic        discharge_reset;
    logic        external_output_on;
    logic        woke_from_sleep;
  } tick_t;

  typedef struct packed {
    logic [1:0] work_mode;
    logic [3:0] system_state;
    logic       predischarge_fet_on;
    logic       main_discharge_fet_on;
    logic       charge_fet_on;
    logic       protection_fet_enable;
  } result_t;

  typedef struct packed {
    logic       dis;
    logic       dsg_able;
    logic       short_c;
    logic       chg;
    logic [2:0] allow;
    logic       dreset;
    logic       ext;
    logic       wake;
  } fet_ctl_t;

  typedef struct packed {
    logic cm;
    logic md;
    logic pd;
  } fet_bits_t;

endpackage

`default_nettype wire

### rtl/core/bmfs_stream_if.sv
// Valid/ready stream channel carrying one beat of a payload type.
// Used for the tick input and the result output; depends on nothing.
`default_nettype none

interface bmfs_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/core/bmfs_cfg_if.sv
// Register write channel: valid/ready with a register index and write data.
// Widths come from bmfs_pkg.
`default_nettype none

interface bmfs_cfg_if
  import bmfs_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/battery_mode_and_fet_sequencer.sv
// Battery mode and FET sequencer top level: tick input register, state update, result register.
// Depends on bmfs_pkg, bmfs_stream_if, bmfs_cfg_if, bmfs_mode_qual and bmfs_fet_seq.
// Each tick beat is taken into an input register and processed into a result register; it
// accepts a beat every cycle unless the result stalls, and a result is valid once its tick has
// passed both registers; a stalled result holds the input register, one beat deep, before ready
// drops. Registers may be written at any time through cfg, which is always ready, but take
// effect on the next tick processed. A tick with data_valid low drops the work mode to idle,
// restarts the pre-discharge sequence and leaves the system state and FET drives unchanged.
`default_nettype none

module battery_mode_and_fet_sequencer
  import bmfs_pkg::*;
#(
  parameter int RUN_COUNT_WIDTH = 16,
  parameter int CURRENT_WIDTH   = 16
) (
  input  logic           clk,
  input  logic           rst,
  bmfs_cfg_if.sink       cfg,
  bmfs_stream_if.sink    tick,
  bmfs_stream_if.source  result
);

  logic        dsg_threshold;
  logic [15:0] dsg_thr;
  logic [15:0] chg_thr;
  logic [15:0] mode_ticks;
  logic [15:0] pre_ticks;
  logic [9:0]  overlap_ticks;

  logic        in_valid;
  tick_t       in_q;
  logic        out_valid;
  result_t     out_q;
  logic        advance;
  logic        en;

  mode_t       mode_next;
  sys_state_t  sys_state;
  sys_state_t  sys_state_next;
  sys_state_t  sys_class;
  fet_ctl_t    ctl;
  fet_bits_t   fet_next;

  assign dsg_threshold = 1'b0;
  assign cfg.ready = !dsg_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      dsg_thr       <= DSG_THRESHOLD_RESET;
      chg_thr       <= CHG_THRESHOLD_RESET;
      mode_ticks    <= MODE_TICKS_RESET;
      pre_ticks     <= PRE_TICKS_RESET;
      overlap_ticks <= OVERLAP_TICKS_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_DSG_THRESHOLD: dsg_thr       <= cfg.data;
        CFG_CHG_THRESHOLD: chg_thr       <= cfg.data;
        CFG_MODE_TICKS:    mode_ticks    <= cfg.data;
        CFG_PRE_TICKS:     pre_ticks     <= cfg.data;
        CFG_OVERLAP_TICKS: overlap_ticks <= cfg.data[9:0];
        default: begin
        end
      endcase
    end
  end

  assign advance = in_valid && (!out_valid || result.ready);
  assign en = advance;
  assign tick.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick.ready) begin
      in_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      in_q <= tick.payload;
    end
  end

  bmfs_mode_qual #(
    .RUN_COUNT_WIDTH (RUN_COUNT_WIDTH),
    .CURRENT_WIDTH   (CURRENT_WIDTH)
  ) u_mode_qual (
    .clk                 (clk),
    .rst                 (rst),
    .en                  (en),
    .tick_valid          (in_q.data_valid),
    .discharge_current   (in_q.discharge_current),
    .charge_current      (in_q.charge_current),
    .discharge_threshold (dsg_thr),
    .charge_threshold    (chg_thr),
    .mode_ticks          (mode_ticks),
    .mode_next           (mode_next)
  );

  always_comb begin
    sys_class = ST_WORK;
    priority if (in_q.hard_fault) begin
      sys_class = ST_FAULT;
    end else if (in_q.upgrading) begin
      sys_class = ST_UPDATING;
    end else if (in_q.charge_flags[0]) begin
      priority if (|in_q.charge_flags[2:1]) begin
        sys_class = ST_FULL;
      end else if (|in_q.charge_flags[5:3]) begin
        sys_class = ST_CHARGE_FAIL;
      end else if (mode_next == MODE_CHG) begin
        sys_class = ST_CHARGING;
      end else if (mode_next == MODE_DSG) begin
        sys_class = ST_DISCHARGING;
      end else begin
        sys_class = ST_CHARGE_IN;
      end
    end else if (mode_next == MODE_DSG) begin
      sys_class = ST_DISCHARGING;
    end else if (in_q.discharge_flags[4]) begin
      sys_class = ST_SLEEP;
    end else if (in_q.discharge_flags[3]) begin
      sys_class = ST_DISCHARGE_FAIL;
    end else begin
      sys_class = ST_WORK;
    end
  end

  assign sys_state_next = in_q.data_valid ? sys_class : sys_state;

  always_ff @(posedge clk) begin
    if (rst) begin
      sys_state <= ST_WORK;
    end else if (en) begin
      sys_state <= sys_state_next;
    end
  end

  assign ctl.dis      = in_q.discharge_flags[0];
  assign ctl.dsg_able = in_q.discharge_flags[1];
  assign ctl.short_c  = in_q.discharge_flags[2];
  assign ctl.chg      = in_q.charge_flags[6];
  assign ctl.allow    = in_q.allow_flags;
  assign ctl.dreset   = in_q.discharge_reset;
  assign ctl.ext      = in_q.external_output_on;
  assign ctl.wake     = in_q.woke_from_sleep;

  bmfs_fet_seq u_fet_seq (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .tick_valid    (in_q.data_valid),
    .ctl           (ctl),
    .mode          (mode_next),
    .pre_ticks     (pre_ticks),
    .overlap_ticks (overlap_ticks),
    .fet_next      (fet_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q.work_mode             <= mode_next;
      out_q.system_state          <= sys_state_next;
      out_q.predischarge_fet_on   <= fet_next.pd;
      out_q.main_discharge_fet_on <= fet_next.md;
      out_q.charge_fet_on         <= fet_next.cm;
      out_q.protection_fet_enable <= ctl.dis || ctl.chg;
    end
  end

  assign result.valid   = out_valid;
  assign result.payload = out_q;

  a_advance_fills_result: assert property (
    @(posedge clk) disable iff (rst)
    advance |=> out_valid
  ) else $error("processed tick did not reach the result register");

  a_invalid_tick_idles: assert property (
    @(posedge clk) disable iff (rst)
    advance && !in_q.data_valid |=> out_q.work_mode == MODE_IDLE
  ) else $error("invalid tick left the work mode active");

  a_dreset_opens_predischarge: assert property (
    @(posedge clk) disable iff (rst)
    advance && in_q.data_valid && in_q.discharge_reset |=> !out_q.predischarge_fet_on
  ) else $error("pre-discharge FET driven during discharge reset");

  a_invalid_tick_holds_state: assert property (
    @(posedge clk) disable iff (rst)
    advance && !in_q.data_valid |=> out_q.system_state == $past(sys_state)
  ) else $error("invalid tick changed the system state");

endmodule

`default_nettype wire

### rtl/core/bmfs_mode_qual.sv
// Mode qualifier: three saturating run counters and the work mode register.
// Depends on bmfs_pkg.
`default_nettype none

module bmfs_mode_qual
  import bmfs_pkg::*;
#(
  parameter int RUN_COUNT_WIDTH = 16,
  parameter int CURRENT_WIDTH   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        tick_valid,
  input  logic [15:0] discharge_current,
  input  logic [15:0] charge_current,
  input  logic [15:0] discharge_threshold,
  input  logic [15:0] charge_threshold,
  input  logic [15:0] mode_ticks,
  output mode_t       mode_next
);

  localparam logic [RUN_COUNT_WIDTH-1:0] RUN_MAX = '1;
  localparam int CMP_W = (RUN_COUNT_WIDTH > 16) ? RUN_COUNT_WIDTH : 16;
  localparam logic [15:0] CUR_MASK =
    (CURRENT_WIDTH >= 16) ? 16'hFFFF : 16'((32'd1 << CURRENT_WIDTH) - 32'd1);

  function automatic logic [RUN_COUNT_WIDTH-1:0] run_step(
    input logic [RUN_COUNT_WIDTH-1:0] run,
    input logic                       hold
  );
    logic [RUN_COUNT_WIDTH-1:0] r;
    if (!hold) begin
      r = '0;
    end else if (run == RUN_MAX) begin
      r = RUN_MAX;
    end else begin
      r = run + 1'b1;
    end
    return r;
  endfunction

  mode_t                      mode;
  logic [RUN_COUNT_WIDTH-1:0] dsg_run;
  logic [RUN_COUNT_WIDTH-1:0] chg_run;
  logic [RUN_COUNT_WIDTH-1:0] idle_run;
  logic [RUN_COUNT_WIDTH-1:0] dsg_run_next;
  logic [RUN_COUNT_WIDTH-1:0] chg_run_next;
  logic [RUN_COUNT_WIDTH-1:0] idle_run_next;
  logic                       dsg_hi;
  logic                       chg_hi;
  logic [CMP_W-1:0]           ticks_ext;

  assign dsg_hi = (discharge_current & CUR_MASK) > discharge_threshold;
  assign chg_hi = (charge_current & CUR_MASK) > charge_threshold;
  assign ticks_ext = CMP_W'(mode_ticks);

  always_comb begin
    dsg_run_next  = dsg_run;
    chg_run_next  = chg_run;
    idle_run_next = idle_run;
    mode_next     = MODE_IDLE;
    if (tick_valid) begin
      dsg_run_next  = run_step(dsg_run, dsg_hi);
      chg_run_next  = run_step(chg_run, chg_hi);
      idle_run_next = run_step(idle_run, !(dsg_hi || chg_hi));
      mode_next     = mode;
      if (CMP_W'(dsg_run_next) > ticks_ext) begin
        mode_next = MODE_DSG;
      end
      if (CMP_W'(chg_run_next) > ticks_ext) begin
        mode_next = MODE_CHG;
      end
      if (CMP_W'(idle_run_next) > ticks_ext) begin
        mode_next = MODE_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_IDLE;
      dsg_run  <= '0;
      chg_run  <= '0;
      idle_run <= '0;
    end else if (en) begin
      mode     <= mode_next;
      dsg_run  <= dsg_run_next;
      chg_run  <= chg_run_next;
      idle_run <= idle_run_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/bmfs_fet_seq.sv
// Pre-discharge FET sequencer with wake latch and charge/discharge FET forcing.
// Depends on bmfs_pkg.
`default_nettype none

module bmfs_fet_seq
  import bmfs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             tick_valid,
  input  fet_ctl_t         ctl,
  input  mode_t            mode,
  input  logic [15:0]      pre_ticks,
  input  logic [9:0]       overlap_ticks,
  output fet_bits_t        fet_next
);

  seq_step_t          step;
  seq_step_t          step_next;
  seq_step_t          step_wake;
  logic [TIMER_W-1:0] timer;
  logic [TIMER_W-1:0] timer_next;
  logic [TIMER_W-1:0] timer_pre;
  logic [TIMER_W-1:0] timer_inc;
  fet_bits_t          fet;
  logic               wake_pending;
  logic               wake_pending_next;
  logic               act;
  logic [TIMER_W:0]   overlap_end;

  assign act = !ctl.dreset &&
               (((ctl.dis || ctl.dsg_able) && ctl.allow[0]) ||
                (ctl.allow[1] && !ctl.short_c));
  assign overlap_end = {1'b0, pre_ticks} + (TIMER_W + 1)'(overlap_ticks);
  assign timer_pre = (ctl.ext && step_wake == SEQ_PRE) ? pre_ticks : timer;
  assign timer_inc = (&timer_pre) ? timer_pre : timer_pre + 1'b1;

  always_comb begin
    step_wake = step;
    if ((ctl.wake || wake_pending) && ctl.dis && fet.md) begin
      step_wake = SEQ_MAIN;
    end
  end

  // Next step, timer and wake latch.
  always_comb begin
    step_next         = SEQ_PRE;
    timer_next        = '0;
    wake_pending_next = wake_pending || ctl.wake;
    if (tick_valid) begin
      wake_pending_next = 1'b0;
      if (act) begin
        unique case (step_wake)
          SEQ_PRE: begin
            timer_next = timer_inc;
            step_next  = (timer_inc > pre_ticks) ? SEQ_OVERLAP : SEQ_PRE;
          end
          SEQ_OVERLAP: begin
            if ({1'b0, timer_inc} > overlap_end) begin
              step_next  = SEQ_MAIN;
              timer_next = '0;
            end else begin
              step_next  = SEQ_OVERLAP;
              timer_next = timer_inc;
            end
          end
          SEQ_MAIN: begin
            step_next  = SEQ_MAIN;
            timer_next = timer;
          end
          default: begin
            step_next  = SEQ_PRE;
            timer_next = '0;
          end
        endcase
      end
    end
  end

  // FET drives.
  always_comb begin
    fet_next = fet;
    if (tick_valid) begin
      fet_next.pd = 1'b0;
      fet_next.md = 1'b0;
      if (act) begin
        unique case (step_wake)
          SEQ_PRE: begin
            fet_next.pd = 1'b1;
            fet_next.md = ctl.ext;
          end
          SEQ_OVERLAP: begin
            fet_next.pd = 1'b1;
            fet_next.md = 1'b1;
          end
          SEQ_MAIN: begin
            fet_next.md = 1'b1;
          end
          default: begin
            fet_next.pd = 1'b0;
          end
        endcase
      end
      if (mode == MODE_CHG && ctl.chg) begin
        fet_next.md = 1'b1;
      end
      fet_next.cm = (mode == MODE_DSG && ctl.dis) ? 1'b1 : ctl.chg;
      if ((ctl.dis || ctl.chg) && ctl.allow[2] && !ctl.short_c) begin
        fet_next.cm = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= SEQ_PRE;
      timer        <= '0;
      fet          <= '0;
      wake_pending <= 1'b0;
    end else if (en) begin
      step         <= step_next;
      timer        <= timer_next;
      fet          <= fet_next;
      wake_pending <= wake_pending_next;
    end
  end

endmodule

`default_nettype wire

### test/bmfs_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the battery mode and FET sequencer testbench: watches the register,
// tick and result channels, predicts every result beat and compares it field by field.
// Depends on bmfs_pkg for the beat types, codes and register reset values.
module bmfs_result_checker
  import bmfs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   tick_valid,
  input  logic                   tick_ready,
  input  tick_t                  tick_beat,
  input  logic                   result_valid,
  input  logic                   result_ready,
  input  result_t                result_beat,
  output int                     mismatches,
  output int                     outstanding,
  output int                     compared
);

  logic [15:0] dsg_thr;
  logic [15:0] chg_thr;
  logic [15:0] qual_ticks;
  logic [15:0] pre_ticks;
  logic [9:0]  ovl_ticks;

  mode_t       mode_now;
  logic [15:0] dsg_streak;
  logic [15:0] chg_streak;
  logic [15:0] rest_streak;
  sys_state_t  state_now;
  logic [1:0]  step_now;
  logic [15:0] step_timer;
  fet_bits_t   fets_now;
  logic        wake_latched;

  result_t     pack_results[$];
  result_t     want;
  int          err_count = 0;
  int          beat_count = 0;

  function automatic logic [15:0] sat_inc(logic [15:0] n);
    return (n == 16'hFFFF) ? n : n + 16'd1;
  endfunction

  task automatic clear_pack_state();
    dsg_thr = DSG_THRESHOLD_RESET;
    chg_thr = CHG_THRESHOLD_RESET;
    qual_ticks = MODE_TICKS_RESET;
    pre_ticks = PRE_TICKS_RESET;
    ovl_ticks = OVERLAP_TICKS_RESET;
    mode_now = MODE_IDLE;
    dsg_streak = '0;
    chg_streak = '0;
    rest_streak = '0;
    state_now = ST_WORK;
    step_now = SEQ_PRE;
    step_timer = '0;
    fets_now = '0;
    wake_latched = 1'b0;
  endtask

  function automatic result_t predict_pack(tick_t t);
    result_t    r;
    sys_state_t st;
    logic       dis, dsg_able, short_c, dis_prot, sleep_f, chg;
    logic       dsg_hi, chg_hi, act, pd, md, cm;
    dis = t.discharge_flags[0];
    dsg_able = t.discharge_flags[1];
    short_c = t.discharge_flags[2];
    dis_prot = t.discharge_flags[3];
    sleep_f = t.discharge_flags[4];
    chg = t.charge_flags[6];
    if (!t.data_valid) begin
      mode_now = MODE_IDLE;
      step_now = SEQ_PRE;
      step_timer = '0;
      if (t.woke_from_sleep) wake_latched = 1'b1;
    end else begin
      dsg_hi = t.discharge_current > dsg_thr;
      chg_hi = t.charge_current > chg_thr;
      dsg_streak = dsg_hi ? sat_inc(dsg_streak) : 16'd0;
      if (dsg_streak > qual_ticks) mode_now = MODE_DSG;
      chg_streak = chg_hi ? sat_inc(chg_streak) : 16'd0;
      if (chg_streak > qual_ticks) mode_now = MODE_CHG;
      rest_streak = !(dsg_hi || chg_hi) ? sat_inc(rest_streak) : 16'd0;
      if (rest_streak > qual_ticks) mode_now = MODE_IDLE;

      if (t.hard_fault) st = ST_FAULT;
      else if (t.upgrading) st = ST_UPDATING;
      else if (t.charge_flags[0]) begin
        if (|t.charge_flags[2:1]) st = ST_FULL;
        else if (|t.charge_flags[5:3]) st = ST_CHARGE_FAIL;
        else if (mode_now == MODE_CHG) st = ST_CHARGING;
        else if (mode_now == MODE_DSG) st = ST_DISCHARGING;
        else st = ST_CHARGE_IN;
      end else if (mode_now == MODE_DSG) st = ST_DISCHARGING;
      else if (sleep_f) st = ST_SLEEP;
      else if (dis_prot) st = ST_DISCHARGE_FAIL;
      else st = ST_WORK;
      state_now = st;

      pd = fets_now.pd;
      md = fets_now.md;
      cm = fets_now.cm;

      if (t.woke_from_sleep || wake_latched) begin
        if (dis && md) step_now = SEQ_MAIN;
        wake_latched = 1'b0;
      end

      act = ((dis || dsg_able) && t.allow_flags[0]) || (t.allow_flags[1] && !short_c);
      if (t.discharge_reset) act = 1'b0;

      if (act) begin
        case (step_now)
          SEQ_PRE: begin
            pd = 1'b1;
            md = 1'b0;
            if (t.external_output_on) begin
              md = 1'b1;
              step_timer = pre_ticks;
            end
            step_timer = sat_inc(step_timer);
            if (step_timer > pre_ticks) step_now = SEQ_OVERLAP;
          end
          SEQ_OVERLAP: begin
            pd = 1'b1;
            md = 1'b1;
            step_timer = sat_inc(step_timer);
            if (int'(step_timer) > int'(pre_ticks) + int'(ovl_ticks)) begin
              step_now = SEQ_MAIN;
              step_timer = '0;
            end
          end
          SEQ_MAIN: begin
            pd = 1'b0;
            md = 1'b1;
          end
          default: begin
            step_now = SEQ_PRE;
            step_timer = '0;
            pd = 1'b0;
            md = 1'b0;
          end
        endcase
      end else begin
        step_now = SEQ_PRE;
        step_timer = '0;
        pd = 1'b0;
        md = 1'b0;
      end

      if (mode_now == MODE_CHG && chg) md = 1'b1;
      if (mode_now == MODE_DSG && dis) cm = 1'b1;
      else cm = chg;
      if ((dis || chg) && t.allow_flags[2] && !short_c) cm = 1'b1;

      fets_now.pd = pd;
      fets_now.md = md;
      fets_now.cm = cm;
    end
    r.work_mode = mode_now;
    r.system_state = state_now;
    r.predischarge_fet_on = fets_now.pd;
    r.main_discharge_fet_on = fets_now.md;
    r.charge_fet_on = fets_now.cm;
    r.protection_fet_enable = dis || chg;
    return r;
  endfunction

  task automatic check_field(string name, int expected_val, int actual_val);
    if (expected_val != actual_val) begin
      $error("%s: expected %0d, got %0d", name, expected_val, actual_val);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_pack_state();
      pack_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DSG_THRESHOLD: dsg_thr = cfg_data;
          CFG_CHG_THRESHOLD: chg_thr = cfg_data;
          CFG_MODE_TICKS:    qual_ticks = cfg_data;
          CFG_PRE_TICKS:     pre_ticks = cfg_data;
          CFG_OVERLAP_TICKS: ovl_ticks = cfg_data[9:0];
          default: ;
        endcase
      end
      if (tick_valid && tick_ready) pack_results.push_back(predict_pack(tick_beat));
      if (result_valid && result_ready) begin
        if (pack_results.size() == 0) begin
          $error("result beat arrived with no tick outstanding");
          err_count++;
        end else begin
          want = pack_results.pop_front();
          beat_count++;
          check_field("work_mode", want.work_mode, result_beat.work_mode);
          check_field("system_state", want.system_state, result_beat.system_state);
          check_field("predischarge_fet_on", want.predischarge_fet_on,
                      result_beat.predischarge_fet_on);
          check_field("main_discharge_fet_on", want.main_discharge_fet_on,
                      result_beat.main_discharge_fet_on);
          check_field("charge_fet_on", want.charge_fet_on, result_beat.charge_fet_on);
          check_field("protection_fet_enable", want.protection_fet_enable,
                      result_beat.protection_fet_enable);
        end
      end
    end
    mismatches <= err_count;
    outstanding <= pack_results.size();
    compared <= beat_count;
  end

endmodule

### test/tb_battery_mode_and_fet_sequencer.sv
`timescale 1ns / 1ps
// Testbench top for the battery mode and FET sequencer: clock, reset, tick and register
// stimulus, result back-pressure and the verdict. Depends on bmfs_pkg, the channel
// interfaces, the block itself and bmfs_result_checker.
module tb_battery_mode_and_fet_sequencer;
  import bmfs_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD_CYCLES = 200;
  localparam int WALK_TICKS = 40;
  localparam int PHASE_TICKS = 80;

  logic clk = 1'b0;
  logic rst;

  bmfs_cfg_if cfg_ch ();
  bmfs_stream_if #(.payload_t(tick_t)) tick_ch ();
  bmfs_stream_if #(.payload_t(result_t)) result_ch ();

  int mismatches;
  int outstanding;
  int compared;
  int cycles = 0;
  int ticks_sent = 0;
  int settings = 0;

  logic idle_on = 1'b0;
  logic long_hold_req = 1'b0;
  logic quiet_tail = 1'b0;
  logic [15:0] dsg_thr;
  logic [15:0] chg_thr;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  battery_mode_and_fet_sequencer dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .tick(tick_ch),
    .result(result_ch)
  );

  bmfs_result_checker u_checker (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_ch.valid),
    .cfg_ready(cfg_ch.ready),
    .cfg_index(cfg_ch.index),
    .cfg_data(cfg_ch.data),
    .tick_valid(tick_ch.valid),
    .tick_ready(tick_ch.ready),
    .tick_beat(tick_ch.payload),
    .result_valid(result_ch.valid),
    .result_ready(result_ch.ready),
    .result_beat(result_ch.payload),
    .mismatches(mismatches),
    .outstanding(outstanding),
    .compared(compared)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_battery_mode_and_fet_sequencer: errors");
      $finish;
    end
  end

  initial begin
    int stall;
    logic hold_done;
    stall = 0;
    hold_done = 1'b0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        result_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        result_ch.ready <= 1'b0;
      end else if (long_hold_req && !hold_done) begin
        hold_done = 1'b1;
        stall = LONG_HOLD_CYCLES - 1;
        result_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 13) - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  function automatic logic [15:0] current_over(logic [15:0] thr);
    if (thr == 16'hFFFF) return thr;
    return 16'($urandom_range(int'(thr) + 1, 65535));
  endfunction

  function automatic logic [15:0] current_under(logic [15:0] thr);
    return 16'($urandom_range(0, int'(thr)));
  endfunction

  function automatic logic [15:0] pick_threshold();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 3000));
    endcase
  endfunction

  function automatic tick_t noise_tick();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(tick_t)-1:0];
  endfunction

  function automatic tick_t saturating_tick();
    tick_t t;
    t = noise_tick();
    t.data_valid = 1'b1;
    t.discharge_current = 16'($urandom_range(1, 65535));
    t.discharge_flags[0] = 1'b1;
    t.allow_flags[0] = 1'b1;
    t.discharge_reset = 1'b0;
    t.external_output_on = 1'b0;
    t.woke_from_sleep = 1'b0;
    return t;
  endfunction

  task automatic put_tick(tick_t t);
    int gap;
    tick_ch.valid <= 1'b1;
    tick_ch.payload <= t;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    ticks_sent++;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    tick_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic set_config(logic [15:0] dsg, logic [15:0] chg, logic [15:0] qual,
                            logic [15:0] pre, logic [9:0] ovl);
    drain();
    write_reg(CFG_DSG_THRESHOLD, dsg);
    write_reg(CFG_CHG_THRESHOLD, chg);
    write_reg(CFG_MODE_TICKS, qual);
    write_reg(CFG_PRE_TICKS, pre);
    write_reg(CFG_OVERLAP_TICKS, {6'd0, ovl});
    cfg_ch.valid <= 1'b0;
    dsg_thr = dsg;
    chg_thr = chg;
    settings++;
  endtask

  task automatic run_scenario(int len);
    tick_t      t;
    int         regime;
    int         k;
    logic [6:0] cf;
    logic [4:0] df;
    logic [2:0] allow;
    logic       hard;
    logic       upg;
    logic       noisy;
    regime = $urandom_range(0, 2);
    noisy = ($urandom_range(0, 7) == 0);
    cf = 7'($urandom);
    if ($urandom_range(0, 1) == 0) cf[5:0] = 6'd0;
    df = 5'($urandom);
    if ($urandom_range(0, 3) != 0) df[0] = 1'b1;
    allow = 3'($urandom);
    if ($urandom_range(0, 3) != 0) allow[0] = 1'b1;
    hard = ($urandom_range(0, 7) == 0);
    upg = ($urandom_range(0, 7) == 0);
    idle_on <= !quiet_tail && ($urandom_range(0, 3) != 0);
    repeat (len) begin
      if (noisy) begin
        t = noise_tick();
      end else begin
        t.data_valid = ($urandom_range(0, 19) != 0);
        case (regime)
          0: begin
            t.discharge_current = current_over(dsg_thr);
            t.charge_current = current_under(chg_thr);
          end
          1: begin
            t.discharge_current = current_under(dsg_thr);
            t.charge_current = current_over(chg_thr);
          end
          default: begin
            t.discharge_current = current_under(dsg_thr);
            t.charge_current = current_under(chg_thr);
          end
        endcase
        t.charge_flags = cf;
        if ($urandom_range(0, 9) == 0) begin
          k = $urandom_range(0, 6);
          t.charge_flags[k] = ~t.charge_flags[k];
        end
        t.discharge_flags = df;
        if ($urandom_range(0, 9) == 0) begin
          k = $urandom_range(0, 4);
          t.discharge_flags[k] = ~t.discharge_flags[k];
        end
        t.hard_fault = hard;
        t.upgrading = upg;
        t.allow_flags = allow;
        t.discharge_reset = ($urandom_range(0, 15) == 0);
        t.external_output_on = ($urandom_range(0, 11) == 0);
        t.woke_from_sleep = ($urandom_range(0, 11) == 0);
      end
      put_tick(t);
    end
  endtask

  task automatic run_phase(int target);
    int n;
    int len;
    n = 0;
    while (n < target) begin
      len = $urandom_range(4, 30);
      run_scenario(len);
      n += len;
    end
  endtask

  initial begin
    rst = 1'b1;
    tick_ch.valid = 1'b0;
    tick_ch.payload = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    dsg_thr = DSG_THRESHOLD_RESET;
    chg_thr = CHG_THRESHOLD_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    put_tick('0);
    put_tick('1);
    put_tick({1'b1, 16'hFFFF, 16'd0, 7'h00, 5'h03, 1'b0, 1'b0, 3'b001, 1'b0, 1'b0, 1'b0});
    put_tick({1'b1, 16'hFFFF, 16'd0, 7'h00, 5'h03, 1'b0, 1'b0, 3'b001, 1'b0, 1'b1, 1'b0});
    put_tick({1'b1, 16'hFFFF, 16'd0, 7'h00, 5'h03, 1'b0, 1'b0, 3'b001, 1'b0, 1'b0, 1'b0});
    put_tick({1'b0, 16'hFFFF, 16'd0, 7'h00, 5'h03, 1'b0, 1'b0, 3'b001, 1'b0, 1'b0, 1'b1});
    put_tick({1'b1, 16'hFFFF, 16'd0, 7'h00, 5'h03, 1'b0, 1'b0, 3'b001, 1'b0, 1'b0, 1'b0});
    put_tick({1'b1, 16'd500, 16'd0, 7'h00, 5'h03, 1'b0, 1'b0, 3'b001, 1'b1, 1'b0, 1'b0});
    put_tick({1'b1, 16'd0, 16'd0, 7'h01, 5'h00, 1'b1, 1'b1, 3'b000, 1'b0, 1'b0, 1'b0});
    put_tick({1'b1, 16'd0, 16'd0, 7'h01, 5'h00, 1'b0, 1'b1, 3'b000, 1'b0, 1'b0, 1'b0});
    put_tick({1'b1, 16'd0, 16'd0, 7'h05, 5'h00, 1'b0, 1'b0, 3'b000, 1'b0, 1'b0, 1'b0});
    put_tick({1'b1, 16'd0, 16'd0, 7'h09, 5'h00, 1'b0, 1'b0, 3'b000, 1'b0, 1'b0, 1'b0});
    put_tick({1'b1, 16'd0, 16'd0, 7'h41, 5'h00, 1'b0, 1'b0, 3'b000, 1'b0, 1'b0, 1'b0});
    put_tick({1'b1, 16'd0, 16'd0, 7'h00, 5'h10, 1'b0, 1'b0, 3'b000, 1'b0, 1'b0, 1'b0});
    put_tick({1'b1, 16'd0, 16'd0, 7'h00, 5'h08, 1'b0, 1'b0, 3'b000, 1'b0, 1'b0, 1'b0});
    put_tick({1'b1, 16'd0, 16'd0, 7'h00, 5'h05, 1'b0, 1'b0, 3'b010, 1'b0, 1'b0, 1'b0});
    put_tick({1'b1, 16'd0, 16'd0, 7'h40, 5'h00, 1'b0, 1'b0, 3'b110, 1'b0, 1'b0, 1'b0});
    put_tick({1'b1, 16'd0, 16'hFFFF, 7'h40, 5'h00, 1'b0, 1'b0, 3'b100, 1'b0, 1'b0, 1'b0});
    put_tick({1'b1, 16'd300, 16'd200, 7'h00, 5'h01, 1'b0, 1'b0, 3'b001, 1'b0, 1'b0, 1'b0});
    put_tick({1'b1, 16'd301, 16'd201, 7'h00, 5'h01, 1'b0, 1'b0, 3'b001, 1'b0, 1'b0, 1'b0});

    set_config(16'd0, 16'd0, 16'd0, 16'd0, 10'd0);
    long_hold_req <= 1'b1;
    run_phase(PHASE_TICKS);
    repeat (4) begin
      set_config(pick_threshold(), pick_threshold(), 16'($urandom_range(0, 6)),
                 16'($urandom_range(0, 8)), 10'($urandom_range(0, 4)));
      run_phase(PHASE_TICKS);
    end

    idle_on <= 1'b0;
    set_config(16'd0, 16'hFFFF, 16'd2, 16'd20, 10'd8);
    repeat (WALK_TICKS) put_tick(saturating_tick());
    drain();
    write_reg(CFG_MODE_TICKS, 16'hFFFE);
    cfg_ch.valid <= 1'b0;
    settings++;
    repeat (4) put_tick(saturating_tick());

    quiet_tail <= 1'b1;
    set_config(pick_threshold(), pick_threshold(), 16'($urandom_range(0, 6)),
               16'($urandom_range(0, 8)), 10'($urandom_range(0, 4)));
    run_phase(PHASE_TICKS);

    drain();
    repeat (8) @(posedge clk);
    $display("Drove %0d ticks under %0d register settings and compared %0d results.",
             ticks_sent, settings, compared);
    $display("The runs included a long result stall and a full pre-discharge walk.");
    if (mismatches == 0) begin
      $display("tb_battery_mode_and_fet_sequencer: clean");
    end else begin
      $display("tb_battery_mode_and_fet_sequencer: errors");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/bmfs_pkg.sv
rtl/core/bmfs_stream_if.sv
rtl/core/bmfs_cfg_if.sv
rtl/core/bmfs_mode_qual.sv
rtl/core/bmfs_fet_seq.sv
rtl/core/battery_mode_and_fet_sequencer.sv
test/bmfs_result_checker.sv
test/tb_battery_mode_and_fet_sequencer.sv
